[rtl/rcc_pkg.sv]
// ----------------------------------------------------------------------------
// rcc_pkg
// Shared constants and types for the 3x3 RGB convolution block.
// ----------------------------------------------------------------------------
package rcc_pkg;

    localparam int LINE_DEPTH = 1024;
    localparam int ADDR_W     = $clog2(LINE_DEPTH);
    localparam int COEF_W     = 16;
    localparam int TAPS       = 9;
    localparam int PROD_W     = COEF_W + 9;
    localparam int ACC_W      = PROD_W + 4;
    localparam int PLANES     = 3;

    localparam logic [2:0] REG_COEF_TOP = 3'd0;
    localparam logic [2:0] REG_COEF_MID = 3'd1;
    localparam logic [2:0] REG_COEF_LOW = 3'd2;
    localparam logic [2:0] REG_DIVISOR  = 3'd3;
    localparam logic [2:0] REG_WIDTH    = 3'd4;
    localparam logic [2:0] REG_HEIGHT   = 3'd5;

    typedef logic [7:0]        sample_t;
    typedef logic [23:0]       pixel_t;
    typedef logic [COEF_W-1:0] coef_t;

    typedef struct packed {
        coef_t [TAPS-1:0] coef;
        logic [15:0]      divisor;
    } rcc_lane_cfg_t;

    typedef struct packed {
        logic    done;
        sample_t result;
    } rcc_lane_stat_t;

endpackage

[rtl/rcc_lane.sv]
// ----------------------------------------------------------------------------
// rcc_lane
// One color plane: 9-tap MAC, optional restoring divide, clamp to 0..255.
// ----------------------------------------------------------------------------
module rcc_lane
    import rcc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  sample_t [TAPS-1:0]     samples,
    input  rcc_lane_cfg_t          cfg,
    output rcc_lane_stat_t         stat
);

    typedef enum logic [3:0] {
        L_IDLE = 4'b0001,
        L_MUL  = 4'b0010,
        L_DIV  = 4'b0100,
        L_DONE = 4'b1000
    } lane_state_t;

    lane_state_t              state_reg, state_next;
    logic [3:0]               step_reg, step_next;
    logic [4:0]               bit_reg, bit_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic [ACC_W-1:0]         quo_reg, quo_next;
    logic [15:0]              rem_reg, rem_next;
    sample_t                  res_reg, res_next;

    logic signed [ACC_W-1:0]  acc_sum;
    logic [ACC_W-1:0]         acc_mag;
    logic [16:0]              rem_sh;
    logic                     q_bit;
    logic [ACC_W-1:0]         quo_shift;

    function automatic sample_t sat8(logic [ACC_W-1:0] mag, logic neg);
        if (neg)
            return 8'd0;
        else if (mag > ACC_W'(255))
            return 8'd255;
        else
            return mag[7:0];
    endfunction

    assign acc_sum = acc_reg + ACC_W'(prod_reg);
    assign acc_mag = acc_sum[ACC_W-1] ? ACC_W'(-acc_sum) : ACC_W'(acc_sum);
    assign rem_sh  = {rem_reg, quo_reg[ACC_W-1]};
    assign q_bit   = rem_sh >= {1'b0, cfg.divisor};
    assign quo_shift = {quo_reg[ACC_W-2:0], q_bit};

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        bit_next   = bit_reg;
        prod_next  = prod_reg;
        acc_next   = acc_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        res_next   = res_reg;
        unique case (state_reg)
            L_IDLE:
            begin
                if (start)
                begin
                    state_next = L_MUL;
                    step_next  = 4'd0;
                    acc_next   = '0;
                    prod_next  = '0;
                end
            end
            L_MUL:
            begin
                if (step_reg < 4'(TAPS))
                    prod_next = $signed({1'b0, samples[step_reg]})
                                * $signed(cfg.coef[step_reg]);
                acc_next  = acc_sum;
                step_next = step_reg + 4'd1;
                if (step_reg == 4'(TAPS))
                begin
                    if (cfg.divisor > 16'd1)
                    begin
                        state_next = L_DIV;
                        quo_next   = acc_mag;
                        rem_next   = '0;
                        bit_next   = '0;
                    end
                    else
                    begin
                        state_next = L_DONE;
                        res_next   = sat8(acc_mag, acc_sum[ACC_W-1]);
                    end
                end
            end
            L_DIV:
            begin
                rem_next = q_bit ? 16'(rem_sh - {1'b0, cfg.divisor}) : rem_sh[15:0];
                quo_next = quo_shift;
                bit_next = bit_reg + 5'd1;
                if (bit_reg == 5'(ACC_W - 1))
                begin
                    state_next = L_DONE;
                    res_next   = sat8(quo_shift, acc_reg[ACC_W-1]);
                end
            end
            L_DONE:
            begin
                state_next = L_IDLE;
            end
            default:
            begin
                state_next = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            step_reg  <= '0;
            bit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            bit_reg   <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        res_reg  <= res_next;
    end

    assign stat.done   = (state_reg == L_DONE);
    assign stat.result = res_reg;

    // divide only runs for a real divisor
    a_div_needs_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == L_DIV |-> cfg.divisor > 16'd1)
        else $error("lane divide with divisor <= 1");

    a_done_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == L_DONE |-> $past(state_reg) == L_MUL || $past(state_reg) == L_DIV)
        else $error("lane done without work");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == L_IDLE)
        else $error("lane started while busy");

endmodule

[rtl/rgb_conv3x3_clamp.sv]
// ----------------------------------------------------------------------------
// rgb_conv3x3_clamp
// Streaming 3x3 RGB convolution with line stores, per-plane lanes and clamp.
// ----------------------------------------------------------------------------
//  channel | signals                                         | role
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data          | register write
//  in      | in_valid in_ready red_in green_in blue_in       | pixel in
//          | frame_start                                     |
//  out     | out_valid out_ready red_out green_out blue_out  | result out
//          | out_row out_col                                 |
//
//  Border pixel: accept, line store read, window shift.
//  Interior pixel: the same steps, then the lane MAC, the divide when divisor > 1
//  and the output register load; the three plane lanes run in parallel and
//  the bit-serial divider is the longest step when it runs.
//  A result waiting at the output stalls only the next interior transaction.
//  Reset: counters, window and output valid clear; line stores are not cleared.
// ----------------------------------------------------------------------------
module rgb_conv3x3_clamp
    import rcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  red_in,
    input  logic [7:0]  green_in,
    input  logic [7:0]  blue_in,
    input  logic        frame_start,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  red_out,
    output logic [7:0]  green_out,
    output logic [7:0]  blue_out,
    output logic [15:0] out_row,
    output logic [9:0]  out_col
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_SHIFT = 5'b00100,
        S_CALC  = 5'b01000,
        S_PUSH  = 5'b10000
    } state_t;

    state_t       state_reg, state_next;
    logic [47:0]  coef_top_reg, coef_mid_reg, coef_low_reg;
    logic [15:0]  divisor_reg;
    logic [10:0]  width_reg;
    logic [15:0]  height_reg;
    logic [9:0]   col_reg, col_next;
    logic [15:0]  row_reg, row_next;
    logic [9:0]   cur_col_reg, cur_col_next;
    logic [15:0]  cur_row_reg, cur_row_next;
    pixel_t       pix_reg;
    pixel_t       top_q_reg, mid_q_reg;
    pixel_t       win_reg [3][3];
    logic         out_valid_reg;
    logic [7:0]   red_reg, green_reg, blue_reg;
    logic [15:0]  orow_reg;
    logic [9:0]   ocol_reg;

    pixel_t       older_mem [LINE_DEPTH];
    pixel_t       newer_mem [LINE_DEPTH];

    logic [10:0]  w_eff;
    logic [15:0]  h_eff;
    logic [10:0]  c0, c_inc;
    logic [16:0]  r0, r1, r_inc;
    logic         interior;
    logic         lane_start;

    rcc_lane_cfg_t           lane_cfg;
    sample_t [TAPS-1:0]      lane_smp [PLANES];
    rcc_lane_stat_t          lane_stat [PLANES];

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);

    assign w_eff = (width_reg < 11'd3) ? 11'd3 :
                   (width_reg > 11'(LINE_DEPTH)) ? 11'(LINE_DEPTH) : width_reg;
    assign h_eff = (height_reg < 16'd3) ? 16'd3 : height_reg;

    always_comb
    begin
        c0 = frame_start ? 11'd0 : {1'b0, col_reg};
        r0 = frame_start ? 17'd0 : {1'b0, row_reg};
        r1 = r0;
        if (c0 >= w_eff)
        begin
            c0 = 11'd0;
            r1 = r0 + 17'd1;
        end
        if (r1 >= {1'b0, h_eff})
            r1 = 17'd0;
        cur_col_next = c0[9:0];
        cur_row_next = r1[15:0];
    end

    assign c_inc = {1'b0, cur_col_reg} + 11'd1;
    assign r_inc = {1'b0, cur_row_reg} + 17'd1;
    assign interior = (cur_row_reg >= 16'd2) && (cur_col_reg >= 10'd2);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (state_reg == S_SHIFT)
        begin
            if (c_inc >= w_eff)
            begin
                col_next = '0;
                row_next = (r_inc >= {1'b0, h_eff}) ? 16'd0 : r_inc[15:0];
            end
            else
            begin
                col_next = c_inc[9:0];
                row_next = cur_row_reg;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_READ;
            S_READ:  state_next = S_SHIFT;
            S_SHIFT: state_next = interior ? S_CALC : S_IDLE;
            S_CALC:  if (lane_stat[0].done) state_next = S_PUSH;
            S_PUSH:  if (!out_valid_reg || out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign lane_start = (state_reg == S_SHIFT) && interior;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            coef_top_reg  <= 48'd0;
            coef_mid_reg  <= 48'h10000;
            coef_low_reg  <= 48'd0;
            divisor_reg   <= 16'd1;
            width_reg     <= 11'd1024;
            height_reg    <= 16'd768;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    win_reg[i][j] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_COEF_TOP: coef_top_reg <= cfg_data;
                    REG_COEF_MID: coef_mid_reg <= cfg_data;
                    REG_COEF_LOW: coef_low_reg <= cfg_data;
                    REG_DIVISOR:  divisor_reg  <= cfg_data[15:0];
                    REG_WIDTH:    width_reg    <= cfg_data[10:0];
                    REG_HEIGHT:   height_reg   <= cfg_data[15:0];
                    default:      ;
                endcase
            end
            if (state_reg == S_SHIFT)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    win_reg[i][0] <= win_reg[i][1];
                    win_reg[i][1] <= win_reg[i][2];
                end
                win_reg[0][2] <= top_q_reg;
                win_reg[1][2] <= mid_q_reg;
                win_reg[2][2] <= pix_reg;
            end
            if (state_reg == S_PUSH && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            pix_reg     <= {blue_in, green_in, red_in};
            cur_col_reg <= cur_col_next;
            cur_row_reg <= cur_row_next;
        end
        if (state_reg == S_READ)
        begin
            top_q_reg <= older_mem[cur_col_reg];
            mid_q_reg <= newer_mem[cur_col_reg];
        end
        if (state_reg == S_SHIFT)
        begin
            older_mem[cur_col_reg] <= mid_q_reg;
            newer_mem[cur_col_reg] <= pix_reg;
        end
        if (state_reg == S_PUSH && (!out_valid_reg || out_ready))
        begin
            red_reg   <= lane_stat[0].result;
            green_reg <= lane_stat[1].result;
            blue_reg  <= lane_stat[2].result;
            orow_reg  <= cur_row_reg - 16'd1;
            ocol_reg  <= cur_col_reg - 10'd1;
        end
    end

    always_comb
    begin
        lane_cfg.divisor = divisor_reg;
        for (int j = 0; j < 3; j++)
        begin
            lane_cfg.coef[j]     = coef_top_reg[COEF_W*j +: COEF_W];
            lane_cfg.coef[3 + j] = coef_mid_reg[COEF_W*j +: COEF_W];
            lane_cfg.coef[6 + j] = coef_low_reg[COEF_W*j +: COEF_W];
        end
        for (int p = 0; p < PLANES; p++)
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    lane_smp[p][3*i + j] = win_reg[i][j][8*p +: 8];
    end

    for (genvar p = 0; p < PLANES; p++)
    begin : g_lane
        rcc_lane u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .start   (lane_start),
            .samples (lane_smp[p]),
            .cfg     (lane_cfg),
            .stat    (lane_stat[p])
        );
    end

    assign out_valid = out_valid_reg;
    assign red_out   = red_reg;
    assign green_out = green_reg;
    assign blue_out  = blue_reg;
    assign out_row   = orow_reg;
    assign out_col   = ocol_reg;

    a_lanes_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        lane_stat[0].done == lane_stat[1].done && lane_stat[0].done == lane_stat[2].done)
        else $error("plane lanes out of step");

    a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == S_READ)
        else $error("accepted transaction not read");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SHIFT |-> {1'b0, cur_col_reg} < w_eff)
        else $error("column beyond line width");

    a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
        lane_stat[0].done |-> state_reg == S_CALC)
        else $error("lane result outside calc");

endmodule
